// ===== src/rgb_led_slot_encoder_core_defines.svh =====
// assertion helpers for the slot encoder
`ifndef RGB_LED_SLOT_ENCODER_CORE_DEFINES_SVH
`define RGB_LED_SLOT_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define RLSE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot encoder check failed");

// next-cycle implication
`define RLSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot encoder check failed");

`endif

// ===== src/rlse_pkg.sv =====
package rlse_pkg;

  localparam logic [7:0]  FRAME_INTERVAL    = 8'd100;
  localparam logic [6:0]  SLOT_COUNT        = 7'd75;
  localparam logic [6:0]  LEAD_SLOTS        = 7'd3;
  localparam logic [15:0] SLOT_PERIOD_RESET = 16'd25;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_DATA,
    PH_LOW
  } slot_phase_t;

  typedef struct packed {
    logic       control_tick;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       yellow_on;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic frame_busy;
  } result_t;

endpackage

// ===== src/rgb_led_slot_encoder_core.sv =====
// Slot-frame encoder for an RGB LED data pin shared with a yellow indicator.
// Each item is one base clock; one result item (pin level, frame busy) comes
// back per item, in the cycle after it is taken, from a result register. The
// block takes one item per clock: all per-item work is one pass of short
// logic into the state and result registers, and item_ready drops only while
// the result register holds an item that has not been taken. slot_period
// (cfg_data, reset 25) sets each slot to slot_period+1 items; a new value is
// used at the next slot reload. cfg_ready is always high.
`include "rgb_led_slot_encoder_core_defines.svh"

module rgb_led_slot_encoder_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rlse_pkg::item_t  item,
  output logic             result_valid,
  input  logic             result_ready,
  output rlse_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import rlse_pkg::*;

  logic [15:0] slot_period;
  logic [7:0]  countdown, countdown_next;
  logic        frame_active, frame_active_next;
  logic [6:0]  slot_index, slot_index_next;
  logic [23:0] color_shift, color_shift_next;
  logic [15:0] slot_prescaler, slot_prescaler_next;
  logic        pin_state, pin_state_next;
  slot_phase_t phase, phase_next;
  logic        accept;
  logic        start;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign start      = item.control_tick && (countdown <= 8'd1);

  always_comb begin
    countdown_next      = countdown;
    frame_active_next   = frame_active;
    slot_index_next     = slot_index;
    color_shift_next    = color_shift;
    slot_prescaler_next = slot_prescaler;
    pin_state_next      = pin_state;
    phase_next          = phase;

    if (item.control_tick) begin
      frame_active_next = 1'b0;
      if (start) begin
        countdown_next      = FRAME_INTERVAL;
        color_shift_next    = {item.green, item.red, item.blue};
        slot_index_next     = '0;
        slot_prescaler_next = '0;
        phase_next          = PH_HIGH;
        frame_active_next   = 1'b1;
      end else begin
        countdown_next = countdown - 8'd1;
        // yellow window: decremented count in 3 .. interval-3
        if (countdown > 8'd3 && countdown <= FRAME_INTERVAL - 8'd2) begin
          pin_state_next = item.yellow_on;
        end
      end
    end

    if (frame_active_next) begin
      if (slot_prescaler_next == '0) begin
        if (slot_index_next >= SLOT_COUNT) begin
          frame_active_next = 1'b0;
        end else begin
          if (slot_index_next < LEAD_SLOTS) begin
            pin_state_next = 1'b0;
          end else begin
            case (phase_next)
              PH_HIGH: begin
                pin_state_next = 1'b1;
                phase_next     = PH_DATA;
              end
              PH_DATA: begin
                pin_state_next   = color_shift_next[23];
                color_shift_next = {color_shift_next[22:0], 1'b0};
                phase_next       = PH_LOW;
              end
              PH_LOW: begin
                pin_state_next = 1'b0;
                phase_next     = PH_HIGH;
              end
              default: begin
                pin_state_next = 1'b0;
                phase_next     = PH_HIGH;
              end
            endcase
          end
          slot_index_next     = slot_index_next + 7'd1;
          slot_prescaler_next = slot_period;
        end
      end else begin
        slot_prescaler_next = slot_prescaler_next - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_period    <= SLOT_PERIOD_RESET;
      countdown      <= '0;
      frame_active   <= 1'b0;
      slot_index     <= '0;
      slot_prescaler <= '0;
      pin_state      <= 1'b0;
      phase          <= PH_HIGH;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slot_period <= cfg_data;
      end
      if (accept) begin
        countdown      <= countdown_next;
        frame_active   <= frame_active_next;
        slot_index     <= slot_index_next;
        slot_prescaler <= slot_prescaler_next;
        pin_state      <= pin_state_next;
        phase          <= phase_next;
        result_valid   <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      color_shift       <= color_shift_next;
      result.pin_level  <= pin_state_next;
      result.frame_busy <= frame_active_next;
    end
  end

  `RLSE_ASSERT_NOW(a_slot_index_range, clk, rst, 1'b1, slot_index <= SLOT_COUNT)
  `RLSE_ASSERT_NEXT(a_frame_start, clk, rst, accept && start,
    countdown == FRAME_INTERVAL && frame_active && result.frame_busy)
  `RLSE_ASSERT_NEXT(a_hold_without_item, clk, rst, !accept,
    $stable(countdown) && $stable(slot_index) && $stable(pin_state))

endmodule
